// File: design/dcr_pkg.sv
`timescale 1ns / 1ps

package dcr_pkg;

    localparam int FRAME_W  = 32;
    localparam int LEN_W    = 16;
    localparam int RAW_W    = 16;
    localparam int OFF_W    = 21;
    localparam int CNT_W    = 16;
    localparam int GIDX_W   = 6;
    localparam int KIND_W   = 3;
    localparam int DROP_W   = 32;
    localparam int CHUNK_W  = 6;
    localparam int CLS_W    = 2;

    localparam int MAX_FRAME_CHUNKS_DEF = 32;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [OFF_W-1:0] BUF_BYTES_RESET  = 21'd102400;
    localparam logic [LEN_W-1:0] SINGLE_HDR_BYTES = 16'd4;
    localparam logic [LEN_W-1:0] CHUNK_HDR_BYTES  = 16'd8;
    localparam logic [LEN_W-1:0] MIN_SOI_LEN      = 16'd6;
    localparam logic [DROP_W-1:0] DROP_MAX        = 32'hFFFF_FFFF;

    localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_HDR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STORED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUP      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd5;
    localparam logic [KIND_W-1:0] KIND_GATHER   = 3'd6;

    localparam logic [CLS_W-1:0] CLS_IGNORE = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SINGLE = 2'd1;
    localparam logic [CLS_W-1:0] CLS_BAD    = 2'd2;
    localparam logic [CLS_W-1:0] CLS_CHUNK  = 2'd3;

    typedef struct packed {
        logic [CLS_W-1:0]   cls;
        logic [FRAME_W-1:0] frame_id;
        logic [CNT_W-1:0]   bytes;
        logic [CHUNK_W-1:0] idx;
        logic [CHUNK_W-1:0] total;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [OFF_W-1:0]   offset;
        logic [CNT_W-1:0]   byte_count;
        logic [GIDX_W-1:0]  gather_index;
        logic               dropped_previous;
        logic               frame_complete;
        logic [OFF_W-1:0]   frame_bytes;
        logic [DROP_W-1:0]  dropped_frames;
        logic               last;
    } t_result;

endpackage

// File: design/dcr_in_if.sv
`timescale 1ns / 1ps

interface dcr_in_if;
    import dcr_pkg::*;

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_id;
    logic [LEN_W-1:0]   datagram_len;
    logic               soi_marker;
    logic [RAW_W-1:0]   chunk_index;
    logic [RAW_W-1:0]   chunk_total;

    modport source (
        output valid, frame_id, datagram_len, soi_marker, chunk_index, chunk_total,
        input  ready
    );

    modport sink (
        input  valid, frame_id, datagram_len, soi_marker, chunk_index, chunk_total,
        output ready
    );
endinterface

// File: design/dcr_out_if.sv
`timescale 1ns / 1ps

interface dcr_out_if;
    import dcr_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  result_kind;
    logic [OFF_W-1:0]   offset;
    logic [CNT_W-1:0]   byte_count;
    logic [GIDX_W-1:0]  gather_index;
    logic               dropped_previous;
    logic               frame_complete;
    logic [OFF_W-1:0]   frame_bytes;
    logic [DROP_W-1:0]  dropped_frames;
    logic               last;

    modport source (
        output valid, result_kind, offset, byte_count, gather_index, dropped_previous,
               frame_complete, frame_bytes, dropped_frames, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, offset, byte_count, gather_index, dropped_previous,
               frame_complete, frame_bytes, dropped_frames, last,
        output ready
    );
endinterface

// File: design/dcr_ram.sv
`timescale 1ns / 1ps

module dcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/dcr_front.sv
`timescale 1ns / 1ps

module dcr_front #(
    parameter int MAX_FRAME_CHUNKS = dcr_pkg::MAX_FRAME_CHUNKS_DEF
) (
    dcr_in_if.sink         i_hdr,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output dcr_pkg::t_cmd  o_push_data
);
    import dcr_pkg::*;

    t_cmd cmd;

    always_comb begin
        cmd          = '0;
        cmd.frame_id = i_hdr.frame_id;
        if (i_hdr.datagram_len >= MIN_SOI_LEN && i_hdr.soi_marker) begin
            cmd.cls   = CLS_SINGLE;
            cmd.bytes = i_hdr.datagram_len - SINGLE_HDR_BYTES;
        end else if (i_hdr.datagram_len < CHUNK_HDR_BYTES) begin
            cmd.cls = CLS_IGNORE;
        end else if (i_hdr.chunk_total == '0
                     || i_hdr.chunk_total > RAW_W'(MAX_FRAME_CHUNKS)
                     || i_hdr.chunk_index >= i_hdr.chunk_total) begin
            cmd.cls = CLS_BAD;
        end else begin
            cmd.cls   = CLS_CHUNK;
            cmd.bytes = i_hdr.datagram_len - CHUNK_HDR_BYTES;
            cmd.idx   = i_hdr.chunk_index[CHUNK_W-1:0];
            cmd.total = i_hdr.chunk_total[CHUNK_W-1:0];
        end
    end

    assign o_push_valid = i_hdr.valid;
    assign o_push_data  = cmd;
    assign i_hdr.ready  = i_push_ready;
endmodule

// File: design/dcr_queue.sv
`timescale 1ns / 1ps

module dcr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  dcr_pkg::t_cmd  i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output dcr_pkg::t_cmd  o_pop_data
);
    import dcr_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count, n_count;
    logic           push, pop;

    assign o_push_ready = (r_count != QCW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end
endmodule

// File: design/dcr_back.sv
`timescale 1ns / 1ps

module dcr_back #(
    parameter int MAX_FRAME_CHUNKS = dcr_pkg::MAX_FRAME_CHUNKS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [dcr_pkg::OFF_W-1:0] i_buf_bytes,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  dcr_pkg::t_cmd             i_cmd,
    dcr_out_if.source                 o_res
);
    import dcr_pkg::*;

    localparam int AW    = (MAX_FRAME_CHUNKS > 1) ? $clog2(MAX_FRAME_CHUNKS) : 1;
    localparam int ENT_W = OFF_W + CNT_W;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_WALK_RD    = 3'd1;
    localparam logic [2:0] ST_WALK_EV    = 3'd2;
    localparam logic [2:0] ST_HEAD       = 3'd3;
    localparam logic [2:0] ST_GATHER_RD  = 3'd4;
    localparam logic [2:0] ST_GATHER_OUT = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [FRAME_W-1:0]          r_cur_frame, n_cur_frame;
    logic [CHUNK_W-1:0]          r_exp, n_exp;
    logic [MAX_FRAME_CHUNKS-1:0] r_bits, n_bits;
    logic [CHUNK_W-1:0]          r_tally, n_tally;
    logic [OFF_W-1:0]            r_fill, n_fill;
    logic [DROP_W-1:0]           r_drop, n_drop;
    logic                        r_fc, n_fc;
    logic [OFF_W-1:0]            r_pos, n_pos;
    logic [CHUNK_W-1:0]          r_n, n_n;
    logic [CHUNK_W-1:0]          r_i, n_i;
    logic                        r_out_valid, n_out_valid;

    logic [KIND_W-1:0]           r_kind, n_kind;
    logic [OFF_W-1:0]            r_off, n_off;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_dp, n_dp;
    t_result                     r_out, n_out;

    logic                        slot_free;
    logic                        ram_we;
    logic [ENT_W-1:0]            ram_rdata;
    logic [CNT_W-1:0]            ent_size;
    logic [OFF_W-1:0]            ent_off;
    logic                        bit_i;
    logic                        walk_more;
    logic [CNT_W-1:0]            walk_sz;
    logic [OFF_W:0]              walk_sum;

    logic                        frame_chg;
    logic                        dp;
    logic [MAX_FRAME_CHUNKS-1:0] base_bits;
    logic [CHUNK_W-1:0]          base_tally;
    logic [OFF_W-1:0]            base_fill;
    logic [CHUNK_W-1:0]          base_exp;
    logic                        dup;
    logic [OFF_W:0]              fill_sum;
    logic                        fits;
    logic                        store;
    logic [CHUNK_W-1:0]          new_tally;

    dcr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_FRAME_CHUNKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.idx[AW-1:0]),
        .i_wdata ({base_fill, i_cmd.bytes}),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ent_size  = ram_rdata[CNT_W-1:0];
    assign ent_off   = ram_rdata[ENT_W-1:CNT_W];
    assign bit_i     = r_bits[r_i[AW-1:0]];
    assign slot_free = !r_out_valid || o_res.ready;

    assign walk_more = r_fc && (r_i < r_exp) && (r_i < CHUNK_W'(MAX_FRAME_CHUNKS))
                       && (r_pos < i_buf_bytes);
    assign walk_sz   = bit_i ? ent_size : '0;
    assign walk_sum  = {1'b0, r_pos} + (OFF_W + 1)'(walk_sz);

    assign frame_chg  = (i_cmd.frame_id != r_cur_frame);
    assign dp         = frame_chg && (r_tally != '0) && (r_tally < r_exp);
    assign base_bits  = frame_chg ? '0 : r_bits;
    assign base_tally = frame_chg ? '0 : r_tally;
    assign base_fill  = frame_chg ? '0 : r_fill;
    assign base_exp   = frame_chg ? i_cmd.total : r_exp;
    assign dup        = base_bits[i_cmd.idx[AW-1:0]];
    assign fill_sum   = {1'b0, base_fill} + (OFF_W + 1)'(i_cmd.bytes);
    assign fits       = (fill_sum <= {1'b0, i_buf_bytes});
    assign store      = !dup && fits;
    assign new_tally  = base_tally + CHUNK_W'(store);

    always_comb begin
        n_state     = r_state;
        n_cur_frame = r_cur_frame;
        n_exp       = r_exp;
        n_bits      = r_bits;
        n_tally     = r_tally;
        n_fill      = r_fill;
        n_drop      = r_drop;
        n_fc        = r_fc;
        n_pos       = r_pos;
        n_n         = r_n;
        n_i         = r_i;
        n_kind      = r_kind;
        n_off       = r_off;
        n_cnt       = r_cnt;
        n_dp        = r_dp;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.cls == CLS_CHUNK) begin
                        o_cmd_ready = 1'b1;
                        n_cur_frame = i_cmd.frame_id;
                        n_exp       = base_exp;
                        n_bits      = base_bits;
                        n_tally     = new_tally;
                        n_fill      = base_fill;
                        if (dp && r_drop != DROP_MAX) begin
                            n_drop = r_drop + 1'b1;
                        end
                        n_dp  = dp;
                        n_cnt = i_cmd.bytes;
                        n_off = dup ? '0 : base_fill;
                        if (dup) begin
                            n_kind = KIND_DUP;
                        end else if (fits) begin
                            n_kind = KIND_STORED;
                            ram_we = 1'b1;
                            n_fill = fill_sum[OFF_W-1:0];
                            n_bits[i_cmd.idx[AW-1:0]] = 1'b1;
                        end else begin
                            n_kind = KIND_OVERFLOW;
                        end
                        n_fc    = (new_tally >= base_exp);
                        n_pos   = '0;
                        n_n     = '0;
                        n_i     = '0;
                        n_state = ST_WALK_RD;
                    end else if (slot_free) begin
                        o_cmd_ready          = 1'b1;
                        n_out_valid          = 1'b1;
                        n_out                = '0;
                        n_out.dropped_frames = r_drop;
                        n_out.last           = 1'b1;
                        if (i_cmd.cls == CLS_SINGLE) begin
                            n_out.kind        = KIND_SINGLE;
                            n_out.byte_count  = i_cmd.bytes;
                            n_out.frame_bytes = OFF_W'(i_cmd.bytes);
                        end else if (i_cmd.cls == CLS_BAD) begin
                            n_out.kind = KIND_BAD_HDR;
                        end else begin
                            n_out.kind = KIND_IGNORED;
                        end
                    end
                end
            end
            ST_WALK_RD: begin
                n_state = walk_more ? ST_WALK_EV : ST_HEAD;
            end
            ST_WALK_EV: begin
                if (walk_sum <= {1'b0, i_buf_bytes}) begin
                    n_pos   = walk_sum[OFF_W-1:0];
                    n_n     = r_n + 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = ST_WALK_RD;
                end else begin
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (slot_free) begin
                    n_out_valid            = 1'b1;
                    n_out.kind             = r_kind;
                    n_out.offset           = r_off;
                    n_out.byte_count       = r_cnt;
                    n_out.gather_index     = '0;
                    n_out.dropped_previous = r_dp;
                    n_out.frame_complete   = r_fc;
                    n_out.frame_bytes      = r_pos;
                    n_out.dropped_frames   = r_drop;
                    n_out.last             = (r_n == '0);
                    n_i                    = '0;
                    if (r_n == '0) begin
                        if (r_fc) begin
                            n_cur_frame = '0;
                            n_exp       = '0;
                            n_bits      = '0;
                            n_tally     = '0;
                            n_fill      = '0;
                        end
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_GATHER_RD;
                    end
                end
            end
            ST_GATHER_RD: begin
                n_state = ST_GATHER_OUT;
            end
            ST_GATHER_OUT: begin
                if (slot_free) begin
                    n_out_valid            = 1'b1;
                    n_out.kind             = KIND_GATHER;
                    n_out.offset           = bit_i ? ent_off : '0;
                    n_out.byte_count       = bit_i ? ent_size : '0;
                    n_out.gather_index     = GIDX_W'(r_i);
                    n_out.dropped_previous = r_dp;
                    n_out.frame_complete   = r_fc;
                    n_out.frame_bytes      = r_pos;
                    n_out.dropped_frames   = r_drop;
                    n_out.last             = (r_i == r_n - 1'b1);
                    if (r_i == r_n - 1'b1) begin
                        n_cur_frame = '0;
                        n_exp       = '0;
                        n_bits      = '0;
                        n_tally     = '0;
                        n_fill      = '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_GATHER_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_frame <= '0;
            r_exp       <= '0;
            r_bits      <= '0;
            r_tally     <= '0;
            r_fill      <= '0;
            r_drop      <= '0;
            r_fc        <= 1'b0;
            r_pos       <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_frame <= n_cur_frame;
            r_exp       <= n_exp;
            r_bits      <= n_bits;
            r_tally     <= n_tally;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_fc        <= n_fc;
            r_pos       <= n_pos;
            r_n         <= n_n;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_off  <= n_off;
        r_cnt  <= n_cnt;
        r_dp   <= n_dp;
        r_out  <= n_out;
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.result_kind      = r_out.kind;
    assign o_res.offset           = r_out.offset;
    assign o_res.byte_count       = r_out.byte_count;
    assign o_res.gather_index     = r_out.gather_index;
    assign o_res.dropped_previous = r_out.dropped_previous;
    assign o_res.frame_complete   = r_out.frame_complete;
    assign o_res.frame_bytes      = r_out.frame_bytes;
    assign o_res.dropped_frames   = r_out.dropped_frames;
    assign o_res.last             = r_out.last;
endmodule

// File: design/datagram_chunk_reassembler.sv
`timescale 1ns / 1ps

// Datagram chunk reassembler: takes one datagram header per request and returns one or
// more results, the final one flagged by last. The front classifies a header in the
// cycle it is accepted and parks it in a two-entry queue, so up to two headers are taken
// back to back while the back end is busy or the result register is stalled. The back
// end retires an ignored, single-frame or bad-header request from idle once the result
// register is free; a chunk that does not complete its frame goes through walk-read and
// head. A frame-completing chunk walks the offset/size table twice through its single
// read port with registered read data: a read and an evaluate state per entry to size
// the gather list, then a read and an output state per gather entry. buffer_bytes resets
// to 102400; users must write it only while no request is in flight; it is not enforced.
module datagram_chunk_reassembler #(
    parameter int MAX_FRAME_CHUNKS = dcr_pkg::MAX_FRAME_CHUNKS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [dcr_pkg::OFF_W-1:0] i_cfg_wr_data,
    dcr_in_if.sink                    i_hdr,
    dcr_out_if.source                 o_res
);
    import dcr_pkg::*;

    logic [OFF_W-1:0] r_buf_bytes;
    logic             push_valid, push_ready;
    t_cmd             push_data;
    logic             cmd_valid, cmd_ready;
    t_cmd             cmd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes <= BUF_BYTES_RESET;
        end else if (i_cfg_wr_en) begin
            r_buf_bytes <= i_cfg_wr_data;
        end
    end

    dcr_front #(
        .MAX_FRAME_CHUNKS (MAX_FRAME_CHUNKS)
    ) u_front (
        .i_hdr        (i_hdr),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    dcr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (cmd_valid),
        .i_pop_ready  (cmd_ready),
        .o_pop_data   (cmd_data)
    );

    dcr_back #(
        .MAX_FRAME_CHUNKS (MAX_FRAME_CHUNKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_buf_bytes (r_buf_bytes),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd_data),
        .o_res       (o_res)
    );
endmodule

// File: tb/datagram_chunk_reassembler_tb.sv
`timescale 1ns / 1ps

module datagram_chunk_reassembler_tb;
    import dcr_pkg::*;

    localparam int CHUNK_SLOTS = MAX_FRAME_CHUNKS_DEF;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [LEN_W-1:0]   len;
        logic               soi;
        logic [RAW_W-1:0]   idx;
        logic [RAW_W-1:0]   total;
    } t_hdr_item;

    typedef struct packed {
        t_hdr_item         h;
        logic              typed;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  count;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [OFF_W-1:0]    i_cfg_wr_data;

    dcr_in_if  hdr_bus ();
    dcr_out_if res_bus ();

    datagram_chunk_reassembler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_hdr         (hdr_bus),
        .o_res         (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // reassembly tracker state
    int unsigned         buf_cap = BUF_BYTES_RESET;
    logic [FRAME_W-1:0]  trk_frame = '0;
    int unsigned         trk_expect = 0;
    logic [31:0]         trk_have = '0;
    int unsigned         trk_count = 0;
    int unsigned         trk_fill = 0;
    logic [OFF_W-1:0]    slot_off [CHUNK_SLOTS];
    logic [CNT_W-1:0]    slot_size [CHUNK_SLOTS];
    logic [DROP_W-1:0]   lost_frames = '0;

    t_result             awaited[$];
    t_plan_row           plan[$];
    bit                  steady = 1'b0;
    int unsigned         mismatches = 0;
    int unsigned         requests_sent = 0;
    int unsigned         results_seen = 0;
    int unsigned         frames_done = 0;
    int unsigned         kind_seen [8] = '{default: 0};

    function automatic int unsigned idle_len();
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic restart_tracking(input logic [FRAME_W-1:0] fid, input int unsigned total);
        trk_frame  = fid;
        trk_expect = total;
        trk_have   = '0;
        trk_count  = 0;
        trk_fill   = 0;
    endtask

    task automatic reassemble(input t_hdr_item h);
        t_result     r;
        t_result     g;
        int unsigned csize;
        int unsigned walked;
        int unsigned n_gather;
        int unsigned sz;
        r = '0;
        r.last = 1'b1;
        if (h.len >= MIN_SOI_LEN && h.soi) begin
            r.kind = KIND_SINGLE;
            r.byte_count = h.len - SINGLE_HDR_BYTES;
            r.frame_bytes = OFF_W'(h.len - SINGLE_HDR_BYTES);
            r.dropped_frames = lost_frames;
            awaited.push_back(r);
            return;
        end
        if (h.len < CHUNK_HDR_BYTES) begin
            r.kind = KIND_IGNORED;
            r.dropped_frames = lost_frames;
            awaited.push_back(r);
            return;
        end
        if (h.total == 0 || h.total > CHUNK_SLOTS || h.idx >= h.total) begin
            r.kind = KIND_BAD_HDR;
            r.dropped_frames = lost_frames;
            awaited.push_back(r);
            return;
        end
        csize = h.len - CHUNK_HDR_BYTES;
        walked = 0;
        n_gather = 0;
        if (h.frame != trk_frame) begin
            if (trk_count > 0 && trk_count < trk_expect) begin
                r.dropped_previous = 1'b1;
                if (lost_frames != DROP_MAX) lost_frames++;
            end
            restart_tracking(h.frame, h.total);
        end
        if (trk_have[h.idx[4:0]]) begin
            r.kind = KIND_DUP;
        end else if (trk_fill + csize <= buf_cap) begin
            r.kind = KIND_STORED;
            r.offset = OFF_W'(trk_fill);
            slot_off[h.idx[4:0]] = OFF_W'(trk_fill);
            slot_size[h.idx[4:0]] = CNT_W'(csize);
            trk_fill = (trk_fill + csize) & 32'h1F_FFFF;
            trk_have[h.idx[4:0]] = 1'b1;
            trk_count++;
        end else begin
            r.kind = KIND_OVERFLOW;
            r.offset = OFF_W'(trk_fill);
        end
        if (trk_count >= trk_expect) begin
            r.frame_complete = 1'b1;
            for (int unsigned i = 0; i < trk_expect && i < CHUNK_SLOTS && walked < buf_cap;
                 i++) begin
                sz = trk_have[i] ? slot_size[i] : 0;
                if (walked + sz > buf_cap) break;
                walked += sz;
                n_gather++;
            end
        end
        r.byte_count = CNT_W'(csize);
        r.frame_bytes = OFF_W'(walked);
        r.dropped_frames = lost_frames;
        r.last = (n_gather == 0);
        awaited.push_back(r);
        for (int unsigned i = 0; i < n_gather; i++) begin
            g = r;
            g.kind = KIND_GATHER;
            g.offset = trk_have[i] ? slot_off[i] : '0;
            g.byte_count = trk_have[i] ? slot_size[i] : '0;
            g.gather_index = GIDX_W'(i);
            g.last = (i == n_gather - 1);
            awaited.push_back(g);
        end
        if (r.frame_complete) restart_tracking('0, 0);
    endtask

    task automatic send_request(input t_hdr_item h);
        int unsigned gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            hdr_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        hdr_bus.valid        <= 1'b1;
        hdr_bus.frame_id     <= h.frame;
        hdr_bus.datagram_len <= h.len;
        hdr_bus.soi_marker   <= h.soi;
        hdr_bus.chunk_index  <= h.idx;
        hdr_bus.chunk_total  <= h.total;
        @(posedge i_clk);
        while (!hdr_bus.ready) @(posedge i_clk);
        reassemble(h);
        requests_sent++;
    endtask

    task automatic set_capacity(input int unsigned cap);
        @(negedge i_clk);
        hdr_bus.valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= OFF_W'(cap);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        buf_cap = cap;
    endtask

    function automatic t_hdr_item chunk_hdr(input logic [FRAME_W-1:0] fid,
                                            input int unsigned idx,
                                            input int unsigned total,
                                            input bit big);
        t_hdr_item h;
        h.frame = fid;
        h.soi   = 1'b0;
        h.idx   = RAW_W'(idx);
        h.total = RAW_W'(total);
        if (big) h.len = LEN_W'($urandom_range(CHUNK_HDR_BYTES, 65535));
        else if ($urandom_range(0, 4) == 0) h.len = CHUNK_HDR_BYTES;
        else h.len = CHUNK_HDR_BYTES + LEN_W'($urandom_range(0, 60));
        return h;
    endfunction

    function automatic t_hdr_item noise_hdr();
        t_hdr_item h;
        int unsigned sel;
        h.frame = $urandom();
        h.idx   = RAW_W'($urandom());
        h.total = RAW_W'($urandom());
        h.soi   = 1'b0;
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
            h.len = LEN_W'($urandom_range(0, 7));
            if (h.len < MIN_SOI_LEN) h.soi = $urandom_range(0, 1);
        end else if (sel == 1) begin
            h.soi = 1'b1;
            h.len = LEN_W'($urandom_range(MIN_SOI_LEN, 65535));
        end else begin
            h.len = ($urandom_range(0, 1) == 0) ? LEN_W'($urandom_range(8, 65535))
                                                : LEN_W'($urandom_range(8, 40));
            case ($urandom_range(0, 2))
                0: h.total = '0;
                1: h.total = RAW_W'($urandom_range(CHUNK_SLOTS + 1, 65535));
                default: begin
                    h.total = RAW_W'($urandom_range(1, CHUNK_SLOTS));
                    h.idx = RAW_W'($urandom_range(h.total, 65535));
                end
            endcase
        end
        return h;
    endfunction

    task automatic run_traffic(input int unsigned budget);
        t_hdr_item          h;
        int unsigned        sent;
        int unsigned        total;
        int unsigned        pick;
        int unsigned        tmp;
        int unsigned        roll;
        int unsigned        order[$];
        bit                 big;
        logic [FRAME_W-1:0] fid;
        sent = 0;
        fid = '0;
        while (sent < budget) begin
            if ($urandom_range(0, 99) < 15) begin
                h = noise_hdr();
                send_request(h);
                sent++;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 10) fid = '0;
                else if (roll < 18) fid = '1;
                else if (roll < 25) fid = fid + 1;
                else fid = $urandom();
                roll = $urandom_range(0, 99);
                if (roll < 70) total = $urandom_range(1, 4);
                else if (roll < 90) total = $urandom_range(5, 8);
                else total = CHUNK_SLOTS;
                big = (total <= 4) && ($urandom_range(0, 99) < 15);
                order = {};
                for (int unsigned i = 0; i < total; i++) order.push_back(i);
                for (int unsigned i = total - 1; i > 0; i--) begin
                    pick = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[pick];
                    order[pick] = tmp;
                end
                foreach (order[j]) begin
                    if (sent >= budget) break;
                    if ($urandom_range(0, 99) < 4) continue;
                    h = chunk_hdr(fid, order[j], total, big);
                    send_request(h);
                    sent++;
                    if ($urandom_range(0, 99) < 8) begin
                        send_request(h);
                        sent++;
                    end
                    if (total < CHUNK_SLOTS && $urandom_range(0, 99) < 4) begin
                        h = chunk_hdr(fid, $urandom_range(total, CHUNK_SLOTS - 1), CHUNK_SLOTS,
                                      1'b0);
                        send_request(h);
                        sent++;
                    end
                end
            end
        end
    endtask

    function automatic t_plan_row row(input logic [FRAME_W-1:0] frame,
                                      input int unsigned len, input bit soi,
                                      input int unsigned idx, input int unsigned total,
                                      input bit typed, input logic [KIND_W-1:0] kind,
                                      input int unsigned count);
        t_plan_row p;
        p.h.frame = frame;
        p.h.len   = LEN_W'(len);
        p.h.soi   = soi;
        p.h.idx   = RAW_W'(idx);
        p.h.total = RAW_W'(total);
        p.typed   = typed;
        p.kind    = kind;
        p.count   = CNT_W'(count);
        return p;
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: result_kind expected none actual %0d", $time,
                         res_bus.result_kind);
            return;
        end
        want = awaited.pop_front();
        cmp_field("result_kind", want.kind, res_bus.result_kind);
        cmp_field("offset", want.offset, res_bus.offset);
        cmp_field("byte_count", want.byte_count, res_bus.byte_count);
        cmp_field("gather_index", want.gather_index, res_bus.gather_index);
        cmp_field("dropped_previous", want.dropped_previous, res_bus.dropped_previous);
        cmp_field("frame_complete", want.frame_complete, res_bus.frame_complete);
        cmp_field("frame_bytes", want.frame_bytes, res_bus.frame_bytes);
        cmp_field("dropped_frames", want.dropped_frames, res_bus.dropped_frames);
        cmp_field("last", want.last, res_bus.last);
        results_seen++;
        kind_seen[want.kind]++;
        if (want.last && want.frame_complete && want.kind != KIND_SINGLE) frames_done++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) check_result();
    end

    initial begin : res_sink
        int unsigned hold;
        hold = 0;
        res_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                res_bus.ready <= 1'b0;
                hold--;
            end else begin
                res_bus.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) hold = idle_len();
            end
        end
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, awaited.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_result     fixed;
        int unsigned caps [6];
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        hdr_bus.valid        = 1'b0;
        hdr_bus.frame_id     = '0;
        hdr_bus.datagram_len = '0;
        hdr_bus.soi_marker   = 1'b0;
        hdr_bus.chunk_index  = '0;
        hdr_bus.chunk_total  = '0;
        caps = '{1048576, 1, 300, 102400, 0, 64};

        plan.push_back(row(32'h0, 0, 0, 0, 0, 1, KIND_IGNORED, 0));
        plan.push_back(row(32'hFFFF_FFFF, 3, 1, 16'hFFFF, 16'hFFFF, 1, KIND_IGNORED, 0));
        plan.push_back(row(32'h5, 5, 1, 0, 1, 1, KIND_IGNORED, 0));
        plan.push_back(row(32'h5, 6, 1, 0, 0, 1, KIND_SINGLE, 2));
        plan.push_back(row(32'hFFFF_FFFF, 65535, 1, 16'hFFFF, 16'hFFFF, 1, KIND_SINGLE,
                           65531));
        plan.push_back(row(32'h6, 7, 0, 0, 1, 1, KIND_IGNORED, 0));
        plan.push_back(row(32'h6, 8, 0, 0, 0, 1, KIND_BAD_HDR, 0));
        plan.push_back(row(32'h6, 100, 0, 0, 33, 1, KIND_BAD_HDR, 0));
        plan.push_back(row(32'h6, 100, 0, 5, 5, 1, KIND_BAD_HDR, 0));
        plan.push_back(row(32'h6, 65535, 0, 16'hFFFF, 16'hFFFF, 1, KIND_BAD_HDR, 0));
        plan.push_back(row(32'h0, 100, 0, 0, 3, 0, KIND_STORED, 0));
        plan.push_back(row(32'h0, 8, 0, 2, 3, 0, KIND_STORED, 0));
        plan.push_back(row(32'h7, 108, 0, 1, 3, 0, KIND_STORED, 0));
        plan.push_back(row(32'h7, 108, 0, 1, 3, 0, KIND_DUP, 0));
        plan.push_back(row(32'h7, 20, 0, 4, 5, 0, KIND_STORED, 0));
        plan.push_back(row(32'h7, 9, 0, 0, 3, 0, KIND_STORED, 0));
        plan.push_back(row(32'h9, 1000, 0, 0, 2, 0, KIND_STORED, 0));
        plan.push_back(row(32'hA, 500, 0, 0, 2, 0, KIND_STORED, 0));
        plan.push_back(row(32'hA, 65535, 0, 1, 2, 0, KIND_STORED, 0));
        plan.push_back(row(32'hFFFF_FFFF, 65535, 0, 31, 32, 0, KIND_STORED, 0));
        plan.push_back(row(32'hFFFF_FFFF, 65535, 0, 31, 32, 0, KIND_DUP, 0));
        plan.push_back(row(32'hFFFF_FFFF, 65535, 0, 30, 32, 0, KIND_OVERFLOW, 0));
        plan.push_back(row(32'hAAAA_5555, 8, 0, 0, 1, 0, KIND_STORED, 0));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            send_request(plan[n].h);
            if (plan[n].typed) begin
                fixed = '0;
                fixed.kind = plan[n].kind;
                fixed.byte_count = plan[n].count;
                fixed.frame_bytes = (plan[n].kind == KIND_SINGLE) ? OFF_W'(plan[n].count)
                                                                  : '0;
                fixed.dropped_frames = lost_frames;
                fixed.last = 1'b1;
                void'(awaited.pop_back());
                awaited.push_back(fixed);
            end
        end

        foreach (caps[ph]) begin
            set_capacity(caps[ph] == 0 ? $urandom_range(1, 1048576) : caps[ph]);
            steady = (ph == 3);
            run_traffic(24);
        end

        @(negedge i_clk);
        hdr_bus.valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Sent %0d requests over 7 buffer sizes: %0d results, %0d frames completed,",
                 requests_sent, results_seen, frames_done);
        $display("%0d dropped; by kind: ignored %0d, single %0d, bad %0d, stored %0d,",
                 lost_frames, kind_seen[KIND_IGNORED], kind_seen[KIND_SINGLE],
                 kind_seen[KIND_BAD_HDR], kind_seen[KIND_STORED]);
        $display("dup %0d, overflow %0d, gather %0d",
                 kind_seen[KIND_DUP], kind_seen[KIND_OVERFLOW], kind_seen[KIND_GATHER]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: datagram_chunk_reassembler.f
design/dcr_pkg.sv
design/dcr_in_if.sv
design/dcr_out_if.sv
design/dcr_ram.sv
design/dcr_front.sv
design/dcr_queue.sv
design/dcr_back.sv
design/datagram_chunk_reassembler.sv
tb/datagram_chunk_reassembler_tb.sv
